// ===== rtl/yrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yrgb_pkg : shared constants, types and coefficient tables
// Widths, range levels, matrix coefficients and pipeline stage numbering
// for the YCbCr to RGB converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

    // Coefficient fraction bits (Q2.14 by default)
    localparam int COEF_FRAC_BITS = 14;

    // Port widths
    localparam int SMP_W      = 10;
    localparam int SMP8_W     = 8;
    localparam int OUT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DIM_W      = 14;

    // Level widths
    localparam int BLACK_W = 7;
    localparam int SPAN_W  = 10;

    // Datapath widths
    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int E_W    = SMP_W + 1;
    localparam int LP_W   = 2 * E_W;
    localparam int P_W    = COEF_W + E_W;
    localparam int SUM_W  = P_W + 1;
    localparam int T_W    = SUM_W + E_W;
    localparam int N_W    = T_W + 1;
    localparam int X_W    = N_W + OUT_W + 2;
    localparam int D_W    = 2 * SPAN_W + COEF_FRAC_BITS;
    localparam int D2_W   = D_W + 1;

    // Channels
    localparam int NUM_CH = 3;
    localparam int CH_R   = 0;
    localparam int CH_G   = 1;
    localparam int CH_B   = 2;

    // Pipeline layout: front (differences .. numerator), then per-channel divider
    localparam int FRONT_STG = 5;
    localparam int DIV_STG   = 3 + OUT_W;
    localparam int NSTG      = FRONT_STG + DIV_STG;

    localparam int ST_DIFF = 0;
    localparam int ST_PROD = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_SPAN = 3;
    localparam int ST_ADD  = 4;

    localparam int DV_SCALE = 0;
    localparam int DV_OFFS  = 1;
    localparam int DV_SAT   = 2;

    // Sample levels
    localparam logic [BLACK_W-1:0] BLACK_LIM_8  = BLACK_W'(16);
    localparam logic [BLACK_W-1:0] BLACK_LIM_10 = BLACK_W'(64);
    localparam logic [BLACK_W-1:0] BLACK_FULL   = BLACK_W'(0);
    localparam logic [SMP_W-1:0]   CENTRE_8     = SMP_W'(128);
    localparam logic [SMP_W-1:0]   CENTRE_10    = SMP_W'(512);
    localparam logic [SPAN_W-1:0]  LS_LIM_8     = SPAN_W'(219);
    localparam logic [SPAN_W-1:0]  LS_LIM_10    = SPAN_W'(876);
    localparam logic [SPAN_W-1:0]  CS_LIM_8     = SPAN_W'(224);
    localparam logic [SPAN_W-1:0]  CS_LIM_10    = SPAN_W'(896);
    localparam logic [SPAN_W-1:0]  SPAN_FULL_8  = SPAN_W'(255);
    localparam logic [SPAN_W-1:0]  SPAN_FULL_10 = SPAN_W'(1023);

    // Denominators Ls * Cs * 2^COEF_FRAC_BITS for each range mode
    localparam logic [D_W-1:0] D_LIM_8 =
        (D_W'(LS_LIM_8) * D_W'(CS_LIM_8)) << COEF_FRAC_BITS;
    localparam logic [D_W-1:0] D_LIM_10 =
        (D_W'(LS_LIM_10) * D_W'(CS_LIM_10)) << COEF_FRAC_BITS;
    localparam logic [D_W-1:0] D_FULL_8 =
        (D_W'(SPAN_FULL_8) * D_W'(SPAN_FULL_8)) << COEF_FRAC_BITS;
    localparam logic [D_W-1:0] D_FULL_10 =
        (D_W'(SPAN_FULL_10) * D_W'(SPAN_FULL_10)) << COEF_FRAC_BITS;

    // HD guess for an unspecified matrix
    localparam logic [DIM_W-1:0] HD_MIN_WIDTH  = DIM_W'(1280);
    localparam logic [DIM_W-1:0] SD_MAX_HEIGHT = DIM_W'(576);
    localparam logic [DIM_W-1:0] WIDTH_RST     = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RST    = DIM_W'(1080);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEN_BIT      = 3'd0,
        REG_FULL_RANGE   = 3'd1,
        REG_COLOR_SPACE  = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CSP_UNSPEC = 2'd0,
        CSP_BT601  = 2'd1,
        CSP_BT709  = 2'd2,
        CSP_BT2020 = 2'd3
    } color_space_t;

    typedef enum logic [1:0] {
        MAT_601  = 2'd0,
        MAT_709  = 2'd1,
        MAT_2020 = 2'd2
    } mat_t;

    localparam int NUM_MAT  = 3;
    localparam int NUM_COEF = 4;
    localparam int CF_R_CR  = 0;
    localparam int CF_G_CB  = 1;
    localparam int CF_G_CR  = 2;
    localparam int CF_B_CB  = 3;

    localparam longint MICRO_ONE  = 1000000;
    localparam longint MICRO_HALF = 500000;

    // Matrix entry in millionths to fixed point, ties away from zero
    function automatic longint to_fixed(input longint micro);
        longint mag;
        longint q;
        mag = (micro < 0) ? -micro : micro;
        q   = ((mag <<< COEF_FRAC_BITS) + MICRO_HALF) / MICRO_ONE;
        return (micro < 0) ? -q : q;
    endfunction

    localparam logic signed [COEF_W-1:0] COEF_TBL [NUM_MAT][NUM_COEF] = '{
        '{COEF_W'(to_fixed(1402000)), COEF_W'(to_fixed(-344136)),
          COEF_W'(to_fixed(-714136)), COEF_W'(to_fixed(1772000))},
        '{COEF_W'(to_fixed(1574800)), COEF_W'(to_fixed(-187324)),
          COEF_W'(to_fixed(-468124)), COEF_W'(to_fixed(1855600))},
        '{COEF_W'(to_fixed(1474600)), COEF_W'(to_fixed(-164553)),
          COEF_W'(to_fixed(-571353)), COEF_W'(to_fixed(1881400))}
    };

    // Per-configuration values seen by the datapath
    typedef struct packed {
        logic                     ten;
        logic [BLACK_W-1:0]       black;
        logic [SMP_W-1:0]         centre;
        logic [SPAN_W-1:0]        ls;
        logic [SPAN_W-1:0]        cs;
        logic signed [COEF_W-1:0] cv_r;
        logic signed [COEF_W-1:0] cu_g;
        logic signed [COEF_W-1:0] cv_g;
        logic signed [COEF_W-1:0] cu_b;
        logic [D_W-1:0]           d;
    } cfg_t;

endpackage

// ===== rtl/yrgb_cfg.sv =====
// ----------------------------------------------------------------------------
// yrgb_cfg : configuration registers
// Holds the five registers and decodes range levels, matrix and denominator.
// ----------------------------------------------------------------------------
module yrgb_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yrgb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output yrgb_pkg::cfg_t                   cfg
);

    logic                          ten_reg, ten_next;
    logic                          full_reg, full_next;
    yrgb_pkg::color_space_t        csp_reg, csp_next;
    logic [yrgb_pkg::DIM_W-1:0]    width_reg, width_next;
    logic [yrgb_pkg::DIM_W-1:0]    height_reg, height_next;
    yrgb_pkg::mat_t                mat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        ten_next    = ten_reg;
        full_next   = full_reg;
        csp_next    = csp_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            unique case (yrgb_pkg::reg_idx_t'(cfg_index))
                yrgb_pkg::REG_TEN_BIT:      ten_next    = cfg_data[0];
                yrgb_pkg::REG_FULL_RANGE:   full_next   = cfg_data[0];
                yrgb_pkg::REG_COLOR_SPACE:  csp_next    = yrgb_pkg::color_space_t'(cfg_data[1:0]);
                yrgb_pkg::REG_FRAME_WIDTH:  width_next  = cfg_data;
                yrgb_pkg::REG_FRAME_HEIGHT: height_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_reg    <= 1'b0;
            full_reg   <= 1'b0;
            csp_reg    <= yrgb_pkg::CSP_UNSPEC;
            width_reg  <= yrgb_pkg::WIDTH_RST;
            height_reg <= yrgb_pkg::HEIGHT_RST;
        end
        else
        begin
            ten_reg    <= ten_next;
            full_reg   <= full_next;
            csp_reg    <= csp_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Matrix choice; unspecified falls back on a frame-size guess
    always_comb
    begin
        unique case (csp_reg)
            yrgb_pkg::CSP_BT2020: mat = yrgb_pkg::MAT_2020;
            yrgb_pkg::CSP_BT709:  mat = yrgb_pkg::MAT_709;
            yrgb_pkg::CSP_BT601:  mat = yrgb_pkg::MAT_601;
            yrgb_pkg::CSP_UNSPEC:
            begin
                if (width_reg >= yrgb_pkg::HD_MIN_WIDTH || height_reg > yrgb_pkg::SD_MAX_HEIGHT)
                    mat = yrgb_pkg::MAT_709;
                else
                    mat = yrgb_pkg::MAT_601;
            end
            default: mat = yrgb_pkg::MAT_601;
        endcase
    end

    always_comb
    begin
        cfg.ten    = ten_reg;
        cfg.centre = ten_reg ? yrgb_pkg::CENTRE_10 : yrgb_pkg::CENTRE_8;
        if (full_reg)
        begin
            cfg.black = yrgb_pkg::BLACK_FULL;
            cfg.ls    = ten_reg ? yrgb_pkg::SPAN_FULL_10 : yrgb_pkg::SPAN_FULL_8;
            cfg.cs    = ten_reg ? yrgb_pkg::SPAN_FULL_10 : yrgb_pkg::SPAN_FULL_8;
            cfg.d     = ten_reg ? yrgb_pkg::D_FULL_10 : yrgb_pkg::D_FULL_8;
        end
        else
        begin
            cfg.black = ten_reg ? yrgb_pkg::BLACK_LIM_10 : yrgb_pkg::BLACK_LIM_8;
            cfg.ls    = ten_reg ? yrgb_pkg::LS_LIM_10 : yrgb_pkg::LS_LIM_8;
            cfg.cs    = ten_reg ? yrgb_pkg::CS_LIM_10 : yrgb_pkg::CS_LIM_8;
            cfg.d     = ten_reg ? yrgb_pkg::D_LIM_10 : yrgb_pkg::D_LIM_8;
        end
        cfg.cv_r = yrgb_pkg::COEF_TBL[mat][yrgb_pkg::CF_R_CR];
        cfg.cu_g = yrgb_pkg::COEF_TBL[mat][yrgb_pkg::CF_G_CB];
        cfg.cv_g = yrgb_pkg::COEF_TBL[mat][yrgb_pkg::CF_G_CR];
        cfg.cu_b = yrgb_pkg::COEF_TBL[mat][yrgb_pkg::CF_B_CB];
    end

endmodule

// ===== rtl/yrgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// yrgb_ctrl : pipeline valid bits and stage enables
// One valid bit per stage; a stage loads when it or any later stage holds
// a bubble, or the output is being taken.
// ----------------------------------------------------------------------------
module yrgb_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [yrgb_pkg::NSTG-1:0]   en
);

    logic [yrgb_pkg::NSTG-1:0] v_reg, v_next;

    always_comb
    begin
        // bubble at or after stage k lets stage k move
        for (int k = 0; k < yrgb_pkg::NSTG; k++)
        begin
            en[k] = out_ready || !(&(v_reg | ((yrgb_pkg::NSTG'(1) << k) - yrgb_pkg::NSTG'(1))));
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < yrgb_pkg::NSTG; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[yrgb_pkg::NSTG-1];

`ifndef SYNTHESIS
    // items in flight change only by accepted inputs and taken outputs
    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(v_reg) == $past($countones(v_reg))
                  + ($past(in_valid && in_ready) ? 1 : 0)
                  - ($past(out_valid && out_ready) ? 1 : 0)))
        else $error("pipeline item count mismatch");

    // input is refused only when every stage is full and the output stalls
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |-> (&v_reg && !out_ready))
        else $error("input refused with a bubble in the pipe");

    // a result only appears by moving out of the stage before
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v_reg[yrgb_pkg::NSTG-2]))
        else $error("output valid without an item behind it");
`endif

endmodule

// ===== rtl/yrgb_front.sv =====
// ----------------------------------------------------------------------------
// yrgb_front : offsets, matrix products and numerator
// Five stages: sample offsets, products, green sum, span scaling, numerator.
// ----------------------------------------------------------------------------
module yrgb_front (
    input  logic                                  clk,
    input  logic [yrgb_pkg::FRONT_STG-1:0]        en,
    input  yrgb_pkg::cfg_t                        cfg,
    input  logic [yrgb_pkg::SMP_W-1:0]            luma,
    input  logic [yrgb_pkg::SMP_W-1:0]            blue_diff,
    input  logic [yrgb_pkg::SMP_W-1:0]            red_diff,
    output logic signed [yrgb_pkg::N_W-1:0]       n [yrgb_pkg::NUM_CH]
);

    logic [yrgb_pkg::SMP_W-1:0]          y_m, cb_m, cr_m;
    logic signed [yrgb_pkg::E_W-1:0]     ey_reg, ey_next, eb_reg, eb_next, er_reg, er_next;
    logic signed [yrgb_pkg::E_W-1:0]     cs_s, ls_s;
    logic signed [yrgb_pkg::COEF_W-1:0]  cv_r, cu_g, cv_g, cu_b;
    logic signed [yrgb_pkg::LP_W-1:0]    lp1_reg, lp1_next, lp2_reg, lp3_reg;
    logic signed [yrgb_pkg::P_W-1:0]     pr_reg, pr_next, pgu_reg, pgu_next;
    logic signed [yrgb_pkg::P_W-1:0]     pgv_reg, pgv_next, pb_reg, pb_next;
    logic signed [yrgb_pkg::SUM_W-1:0]   sum_reg [yrgb_pkg::NUM_CH];
    logic signed [yrgb_pkg::SUM_W-1:0]   sum_next [yrgb_pkg::NUM_CH];
    logic signed [yrgb_pkg::T_W-1:0]     t_reg [yrgb_pkg::NUM_CH];
    logic signed [yrgb_pkg::T_W-1:0]     t_next [yrgb_pkg::NUM_CH];
    logic signed [yrgb_pkg::N_W-1:0]     n_reg [yrgb_pkg::NUM_CH];
    logic signed [yrgb_pkg::N_W-1:0]     n_next [yrgb_pkg::NUM_CH];

    assign cs_s = $signed(yrgb_pkg::E_W'(cfg.cs));
    assign ls_s = $signed(yrgb_pkg::E_W'(cfg.ls));
    assign cv_r = cfg.cv_r;
    assign cu_g = cfg.cu_g;
    assign cv_g = cfg.cv_g;
    assign cu_b = cfg.cu_b;

    always_comb
    begin
        // 8-bit mode keeps the low byte only
        y_m  = cfg.ten ? luma      : yrgb_pkg::SMP_W'(luma[yrgb_pkg::SMP8_W-1:0]);
        cb_m = cfg.ten ? blue_diff : yrgb_pkg::SMP_W'(blue_diff[yrgb_pkg::SMP8_W-1:0]);
        cr_m = cfg.ten ? red_diff  : yrgb_pkg::SMP_W'(red_diff[yrgb_pkg::SMP8_W-1:0]);

        ey_next = $signed(yrgb_pkg::E_W'(y_m)  - yrgb_pkg::E_W'(cfg.black));
        eb_next = $signed(yrgb_pkg::E_W'(cb_m) - yrgb_pkg::E_W'(cfg.centre));
        er_next = $signed(yrgb_pkg::E_W'(cr_m) - yrgb_pkg::E_W'(cfg.centre));

        lp1_next = ey_reg * cs_s;
        pr_next  = cv_r * er_reg;
        pgu_next = cu_g * eb_reg;
        pgv_next = cv_g * er_reg;
        pb_next  = cu_b * eb_reg;

        sum_next[yrgb_pkg::CH_R] = yrgb_pkg::SUM_W'(pr_reg);
        sum_next[yrgb_pkg::CH_G] = yrgb_pkg::SUM_W'(pgu_reg) + yrgb_pkg::SUM_W'(pgv_reg);
        sum_next[yrgb_pkg::CH_B] = yrgb_pkg::SUM_W'(pb_reg);

        for (int c = 0; c < yrgb_pkg::NUM_CH; c++)
        begin
            t_next[c] = sum_reg[c] * ls_s;
            n_next[c] = (yrgb_pkg::N_W'(lp3_reg) <<< yrgb_pkg::COEF_FRAC_BITS)
                        + yrgb_pkg::N_W'(t_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[yrgb_pkg::ST_DIFF])
        begin
            ey_reg <= ey_next;
            eb_reg <= eb_next;
            er_reg <= er_next;
        end
        if (en[yrgb_pkg::ST_PROD])
        begin
            lp1_reg <= lp1_next;
            pr_reg  <= pr_next;
            pgu_reg <= pgu_next;
            pgv_reg <= pgv_next;
            pb_reg  <= pb_next;
        end
        if (en[yrgb_pkg::ST_SUM])
        begin
            lp2_reg <= lp1_reg;
            sum_reg <= sum_next;
        end
        if (en[yrgb_pkg::ST_SPAN])
        begin
            lp3_reg <= lp2_reg;
            t_reg   <= t_next;
        end
        if (en[yrgb_pkg::ST_ADD])
        begin
            n_reg <= n_next;
        end
    end

    assign n = n_reg;

endmodule

// ===== rtl/yrgb_div.sv =====
// ----------------------------------------------------------------------------
// yrgb_div : per-channel rounding divider
// Forms 2N + D, checks saturation, then one restoring quotient bit a stage.
// ----------------------------------------------------------------------------
module yrgb_div (
    input  logic                                clk,
    input  logic [yrgb_pkg::DIV_STG-1:0]        en,
    input  logic signed [yrgb_pkg::N_W-1:0]     n,
    input  logic [yrgb_pkg::D_W-1:0]            d,
    output logic [yrgb_pkg::OUT_W-1:0]          value
);

    logic [yrgb_pkg::D2_W-1:0]          d2;
    logic signed [yrgb_pkg::X_W-1:0]    m_reg, m_next;
    logic                               pa_reg, pa_next, pb_reg;
    logic [yrgb_pkg::X_W-1:0]           x_reg, x_next;
    logic [yrgb_pkg::X_W-1:0]           rem_reg [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::X_W-1:0]           rem_next [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::OUT_W-1:0]         q_reg [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::OUT_W-1:0]         q_next [yrgb_pkg::OUT_W];
    logic                               pos_reg [yrgb_pkg::OUT_W];
    logic                               pos_next [yrgb_pkg::OUT_W];
    logic                               sat_reg [yrgb_pkg::OUT_W];
    logic                               sat_next [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::X_W-1:0]           shifted [yrgb_pkg::OUT_W];
    logic                               take [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::X_W-1:0]           diff [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::OUT_W-1:0]         qn [yrgb_pkg::OUT_W];
    logic [yrgb_pkg::OUT_W-1:0]         value_reg, value_next;

    assign d2 = {d, 1'b0};

    always_comb
    begin
        // 2N = 2 * 255 * n = (n << 9) - (n << 1)
        m_next  = (yrgb_pkg::X_W'(n) <<< (yrgb_pkg::OUT_W + 1)) - (yrgb_pkg::X_W'(n) <<< 1);
        pa_next = !n[yrgb_pkg::N_W-1] && (n != '0);
        x_next  = $unsigned(m_reg) + yrgb_pkg::X_W'(d);

        rem_next[0] = x_reg;
        q_next[0]   = '0;
        pos_next[0] = pb_reg;
        sat_next[0] = x_reg >= (yrgb_pkg::X_W'(d2) << yrgb_pkg::OUT_W);

        for (int k = 0; k < yrgb_pkg::OUT_W; k++)
        begin
            shifted[k] = yrgb_pkg::X_W'(d2) << (yrgb_pkg::OUT_W - 1 - k);
            take[k]    = rem_reg[k] >= shifted[k];
            diff[k]    = take[k] ? (rem_reg[k] - shifted[k]) : rem_reg[k];
            qn[k]      = {q_reg[k][yrgb_pkg::OUT_W-2:0], take[k]};
        end

        for (int k = 1; k < yrgb_pkg::OUT_W; k++)
        begin
            rem_next[k] = diff[k-1];
            q_next[k]   = qn[k-1];
            pos_next[k] = pos_reg[k-1];
            sat_next[k] = sat_reg[k-1];
        end

        // non-positive numerator clamps low, quotient past 255 clamps high
        if (!pos_reg[yrgb_pkg::OUT_W-1])
            value_next = '0;
        else if (sat_reg[yrgb_pkg::OUT_W-1])
            value_next = '1;
        else
            value_next = qn[yrgb_pkg::OUT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[yrgb_pkg::DV_SCALE])
        begin
            m_reg  <= m_next;
            pa_reg <= pa_next;
        end
        if (en[yrgb_pkg::DV_OFFS])
        begin
            x_reg  <= x_next;
            pb_reg <= pa_reg;
        end
        for (int k = 0; k < yrgb_pkg::OUT_W; k++)
        begin
            if (en[yrgb_pkg::DV_SAT + k])
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                pos_reg[k] <= pos_next[k];
                sat_reg[k] <= sat_next[k];
            end
        end
        if (en[yrgb_pkg::DIV_STG-1])
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/yuv_to_rgb_color_converter.sv =====
// ----------------------------------------------------------------------------
// yuv_to_rgb_color_converter : YCbCr to 8-bit RGB colour converter
// Converts one Y, Cb, Cr item per clock to rounded, saturated R, G, B using
// BT.601, BT.709 or BT.2020 (non-constant luminance) coefficients in signed
// Q2.14, for 8-bit or 10-bit samples in limited or full range. An
// unspecified matrix is taken as BT.709 when the frame is at least 1280
// wide or more than 576 high, else BT.601. The block takes one item every
// clock unless every stage is full and out_ready is low; each item passes
// through the five-stage matrix front end and then the per-channel divider
// (scale, offset, saturation check, eight one-bit restoring divide stages).
// Any bubble in the pipe lets a new item in while a finished result waits.
// Configuration is written through cfg_index / cfg_data (cfg_ready is always
// high) and must only change while no item is in flight.
// ----------------------------------------------------------------------------
module yuv_to_rgb_color_converter (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [yrgb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [yrgb_pkg::CFG_DATA_W-1:0]      cfg_data,

    // input items
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [yrgb_pkg::SMP_W-1:0]           luma,
    input  logic [yrgb_pkg::SMP_W-1:0]           blue_diff,
    input  logic [yrgb_pkg::SMP_W-1:0]           red_diff,

    // result items
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [yrgb_pkg::OUT_W-1:0]           red,
    output logic [yrgb_pkg::OUT_W-1:0]           green,
    output logic [yrgb_pkg::OUT_W-1:0]           blue
);

    yrgb_pkg::cfg_t                         cfg;
    logic [yrgb_pkg::NSTG-1:0]              en;
    logic signed [yrgb_pkg::N_W-1:0]        n_front [yrgb_pkg::NUM_CH];
    logic [yrgb_pkg::OUT_W-1:0]             chan [yrgb_pkg::NUM_CH];

    // Register file and decode of levels, matrix and denominator. The
    // decoded values feed every stage directly, which is safe only if the
    // user writes with the pipe empty; the block does not enforce this.
    yrgb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Valid bits for all 16 stages; the last stage is the output register.
    yrgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    // Numerator n = ey*Cs*2^F + (cu*eb + cv*er)*Ls for all three channels.
    yrgb_front u_front (
        .clk       (clk),
        .en        (en[yrgb_pkg::FRONT_STG-1:0]),
        .cfg       (cfg),
        .luma      (luma),
        .blue_diff (blue_diff),
        .red_diff  (red_diff),
        .n         (n_front)
    );

    // Channel = floor((510n + D) / 2D), clamped to 0..255.
    for (genvar c = 0; c < yrgb_pkg::NUM_CH; c++)
    begin : g_chan
        yrgb_div u_div (
            .clk   (clk),
            .en    (en[yrgb_pkg::NSTG-1:yrgb_pkg::FRONT_STG]),
            .n     (n_front[c]),
            .d     (cfg.d),
            .value (chan[c])
        );
    end

    assign red   = chan[yrgb_pkg::CH_R];
    assign green = chan[yrgb_pkg::CH_G];
    assign blue  = chan[yrgb_pkg::CH_B];

endmodule
